[rtl/pnr_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pnr_pkg
// Types and constants shared by the Newton polynomial root finder.
// ---------------------------------------------------------------------------
package pnr_pkg;

	localparam int NUM_COEF   = 7;
	localparam int DIV_BITS   = 80;
	localparam logic [63:0] TOL_Q32 = 64'd4295;

	typedef enum logic [2:0] {
		REG_DEGREE = 3'd0,
		REG_COEF0  = 3'd1,
		REG_COEF1  = 3'd2,
		REG_COEF2  = 3'd3,
		REG_COEF3  = 3'd4,
		REG_COEF4  = 3'd5,
		REG_COEF5  = 3'd6,
		REG_COEF6  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] start_guess;
	} in_t;

	typedef struct packed {
		logic signed [31:0] estimate;
		logic               found;
		logic [7:0]         iterations;
	} out_t;

	typedef struct packed {
		logic       load_x;
		logic       acc_clr;
		logic       mul_hi;
		logic       mul_lo;
		logic       sat;
		logic       add;
		logic       save_p;
		logic       div_start;
		logic       div_step;
		logic       x_upd;
		logic       out_load;
		logic [2:0] k;
		logic [2:0] fac;
		logic       found;
		logic [7:0] iters;
	} cmd_t;

	typedef struct packed {
		logic       p_small;
		logic       d_zero;
		logic [2:0] deg;
	} sts_t;

endpackage
`default_nettype wire

[rtl/pnr_stream_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pnr_stream_if
// Valid/ready channel carrying one payload of type T.
// ---------------------------------------------------------------------------
interface pnr_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/polynomial_newton_root_finder.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// polynomial_newton_root_finder
// Newton-Raphson root search on a configured integer polynomial, Q16.16.
// ---------------------------------------------------------------------------
// One request runs to completion before the next is taken. Each Newton
// iteration evaluates p(x) and then p'(x) by Horner's rule on the single
// shared 32x32 multiplier, checks |p| against the tolerance and p'(x) for
// zero, runs the bit-serial divider and updates the estimate; a request
// takes up to ITER_LIMIT iterations. A finished result sits in the output
// register and the next request may be accepted meanwhile.
module polynomial_newton_root_finder #(
	parameter int ITER_LIMIT = 200,
	parameter int MAX_DEGREE = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	pnr_stream_if.sink       in_ch,
	pnr_stream_if.source     out_ch
);
	import pnr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	in_t  in_data;
	out_t out_data;

	assign in_data     = in_ch.data;
	assign out_ch.data = out_data;

	pnr_ctrl #(.ITER_LIMIT(ITER_LIMIT)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pnr_dp #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.in_data (in_data),
		.cmd     (cmd),
		.sts     (sts),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

[rtl/pnr_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pnr_dp
// Datapath: config registers, Horner MAC with shared 32x32 multiplier,
// restoring divider, estimate update and result register.
// ---------------------------------------------------------------------------
module pnr_dp #(
	parameter int MAX_DEGREE = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_idx,
	input  wire logic [15:0]   cfg_data,
	input  wire pnr_pkg::in_t  in_data,
	input  wire pnr_pkg::cmd_t cmd,
	output pnr_pkg::sts_t      sts,
	output pnr_pkg::out_t      out_data
);
	import pnr_pkg::*;

	logic [2:0]         deg_q;
	logic signed [15:0] coef_q [NUM_COEF];

	logic signed [31:0] x_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] p_q;
	logic signed [63:0] prod_q;
	logic [63:0]        hi_q;
	logic [63:0]        lo_q;
	logic [63:0]        rem_q;
	logic [63:0]        dsr_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [DIV_BITS-1:0] quo_q;
	out_t               out_q;

	logic [63:0] a_mag;
	logic [31:0] b_mag;
	logic        neg;
	logic [31:0] mul_a;
	logic [63:0] mul_p;
	logic [63:0] m_raw;
	logic [63:0] m_sat;
	logic [63:0] limit;
	logic signed [19:0] term20;
	logic signed [63:0] term;
	logic signed [64:0] sum65;
	logic signed [63:0] sum_sat;
	logic [64:0] rs;
	logic [64:0] rdiff;
	logic [63:0] p_mag;
	logic [48:0] step;
	logic signed [50:0] nx;
	logic signed [31:0] nx_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 3'd1;
			for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			if (reg_idx_t'(cfg_idx) == REG_DEGREE) begin
				deg_q <= cfg_data[2:0];
			end else begin
				coef_q[cfg_idx - 3'd1] <= signed'(cfg_data);
			end
		end
	end

	always_comb begin
		if (deg_q == 3'd0) sts.deg = 3'd1;
		else if (32'(deg_q) > MAX_DEGREE) sts.deg = 3'(MAX_DEGREE);
		else sts.deg = deg_q;
	end

	assign p_mag       = p_q[63] ? 64'(-p_q) : 64'(p_q);
	assign sts.p_small = p_mag <= TOL_Q32;
	assign sts.d_zero  = acc_q == '0;

	// Horner step: |acc| * |x| split in two 32x32 products
	assign a_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
	assign b_mag = x_q[31] ? 32'(-x_q) : 32'(x_q);
	assign neg   = acc_q[63] ^ x_q[31];
	assign mul_a = cmd.mul_hi ? a_mag[63:32] : a_mag[31:0];
	assign mul_p = 64'(mul_a) * 64'(b_mag);

	always_comb begin
		limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		m_raw = (hi_q << 16) + (lo_q >> 16);
		if (hi_q[63:47] != '0) m_sat = limit;
		else if (m_raw > limit) m_sat = limit;
		else m_sat = m_raw;
	end

	assign term20 = signed'({1'b0, cmd.fac}) * coef_q[cmd.k];
	assign term   = {{12{term20[19]}}, term20, 32'd0};
	assign sum65  = 65'(prod_q) + 65'(term);

	always_comb begin
		if (sum65[64] != sum65[63]) begin
			sum_sat = sum65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end else begin
			sum_sat = sum65[63:0];
		end
	end

	// restoring division of (|p| << 16) by |d|
	assign rs    = {rem_q, dvd_q[DIV_BITS-1]};
	assign rdiff = rs - {1'b0, dsr_q};

	always_comb begin
		step = (quo_q[DIV_BITS-1:48] != '0) ? {1'b1, 48'd0} : {1'b0, quo_q[47:0]};
		if (p_q[63] != acc_q[63]) nx = 51'(x_q) + signed'({2'b00, step});
		else nx = 51'(x_q) - signed'({2'b00, step});
		if (nx > 51'sh7FFF_FFFF) nx_sat = 32'sh7FFF_FFFF;
		else if (nx < -51'sh8000_0000) nx_sat = 32'sh8000_0000;
		else nx_sat = nx[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) x_q <= in_data.start_guess;
		else if (cmd.x_upd) x_q <= nx_sat;
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.add) acc_q <= sum_sat;
		if (cmd.mul_hi) hi_q <= mul_p;
		if (cmd.mul_lo) lo_q <= mul_p;
		if (cmd.sat) prod_q <= neg ? 64'(-m_sat) : 64'(m_sat);
		if (cmd.save_p) p_q <= sum_sat;
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= {p_mag, 16'd0};
			dsr_q <= a_mag;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			if (!rdiff[64]) begin
				rem_q <= rdiff[63:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rs[63:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_q.estimate   <= x_q;
			out_q.found      <= cmd.found;
			out_q.iterations <= cmd.iters;
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

[rtl/pnr_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pnr_ctrl
// Sequencer for Horner evaluation of p and p', division and update.
// ---------------------------------------------------------------------------
module pnr_ctrl #(
	parameter int ITER_LIMIT = 200
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire pnr_pkg::sts_t sts,
	output pnr_pkg::cmd_t      cmd
);
	import pnr_pkg::*;

	localparam int IW = $clog2(ITER_LIMIT + 1);
	localparam int CW = $clog2(DIV_BITS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MHI, S_MLO, S_SAT, S_ADD, S_PCHK, S_DCHK, S_DIV, S_UPD, S_DONE
	} state_t;

	state_t        state_q;
	logic [2:0]    k_q;
	logic          deriv_q;
	logic          found_q;
	logic [IW-1:0] iter_q;
	logic [CW-1:0] div_cnt_q;
	logic          out_valid_q;
	logic [2:0]    last_k;
	logic          in_fire;

	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign last_k    = deriv_q ? sts.deg - 3'd1 : sts.deg;

	always_comb begin
		cmd           = '0;
		cmd.k         = k_q;
		cmd.fac       = deriv_q ? sts.deg - k_q : 3'd1;
		cmd.found     = found_q;
		cmd.iters     = (32'(iter_q) > 32'd255) ? 8'hFF : 8'(iter_q);
		cmd.load_x    = in_fire;
		cmd.acc_clr   = in_fire || (state_q == S_PCHK && !sts.p_small) ||
			(state_q == S_UPD);
		cmd.mul_hi    = state_q == S_MHI;
		cmd.mul_lo    = state_q == S_MLO;
		cmd.sat       = state_q == S_SAT;
		cmd.add       = state_q == S_ADD;
		cmd.save_p    = state_q == S_ADD && !deriv_q && k_q == last_k;
		cmd.div_start = state_q == S_DCHK && !sts.d_zero;
		cmd.div_step  = state_q == S_DIV;
		cmd.x_upd     = state_q == S_UPD;
		cmd.out_load  = state_q == S_DONE && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			deriv_q     <= 1'b0;
			found_q     <= 1'b0;
			iter_q      <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						k_q     <= '0;
						deriv_q <= 1'b0;
						found_q <= 1'b0;
						iter_q  <= '0;
						state_q <= S_MHI;
					end
				end
				S_MHI: state_q <= S_MLO;
				S_MLO: state_q <= S_SAT;
				S_SAT: state_q <= S_ADD;
				S_ADD: begin
					if (k_q == last_k) begin
						state_q <= deriv_q ? S_DCHK : S_PCHK;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_MHI;
					end
				end
				S_PCHK: begin
					if (sts.p_small) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						k_q     <= '0;
						deriv_q <= 1'b1;
						state_q <= S_MHI;
					end
				end
				S_DCHK: begin
					if (sts.d_zero) begin
						state_q <= S_DONE;
					end else begin
						div_cnt_q <= CW'(DIV_BITS);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == CW'(1)) state_q <= S_UPD;
				end
				S_UPD: begin
					iter_q  <= iter_q + 1'b1;
					k_q     <= '0;
					deriv_q <= 1'b0;
					if (iter_q + 1'b1 == IW'(ITER_LIMIT)) state_q <= S_DONE;
					else state_q <= S_MHI;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_MHI) else $error("accepted request did not start");
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		32'(iter_q) <= ITER_LIMIT) else $error("iteration count overrun");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_cnt_q != '0) else $error("divider count underflow");

endmodule
`default_nettype wire

[test/polynomial_newton_root_finder_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// polynomial_newton_root_finder_test
// Runs start guesses through the Newton root finder over a series of
// polynomial setups. A local fixed-point model predicts each result, and
// the output stream is checked field by field against it, in order.
// ---------------------------------------------------------------------------
module polynomial_newton_root_finder_test;
	import pnr_pkg::*;

	localparam int ROOT_ITERS = 200;
	localparam int DEG_LIMIT  = 6;
	localparam int STALL_MAX  = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_data;

	pnr_stream_if #(.T(in_t))  in_ch();
	pnr_stream_if #(.T(out_t)) out_ch();

	polynomial_newton_root_finder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	logic [2:0]         degree_reg;
	logic signed [15:0] coef_reg [NUM_COEF];

	in_t  guess_q [$];
	out_t root_q  [$];
	int   errors;
	bit   calm;
	bit   in_took;
	int   out_hold;
	int   stall_cnt;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic longint unsigned mag(longint signed v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint signed sat_mul(longint signed acc, longint signed x);
		bit neg;
		longint unsigned a, b, lim, hi, lo, m;
		neg = (acc < 0) != (x < 0);
		a   = mag(acc);
		b   = mag(x);
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		hi  = (a >> 32) * b;
		lo  = (a & 64'hFFFF_FFFF) * b;
		if (hi >= (64'd1 << 47))
			m = lim;
		else begin
			m = (hi << 16) + (lo >> 16);
			if (m > lim)
				m = lim;
		end
		return neg ? longint'(64'd0 - m) : longint'(m);
	endfunction

	function automatic longint signed sat_add(longint signed a, longint signed b);
		longint signed s;
		s = a + b;
		if (a >= 0 && b >= 0 && s < 0)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (a < 0 && b < 0 && s >= 0)
			return 64'sh8000_0000_0000_0000;
		return s;
	endfunction

	function automatic longint signed horner(longint signed x, int deg, bit deriv);
		longint signed acc;
		longint signed term;
		int top;
		acc = 0;
		top = deriv ? deg - 1 : deg;
		for (int k = 0; k <= top; k++) begin
			term = longint'(coef_reg[k]) * (deriv ? deg - k : 1);
			acc = sat_add(sat_mul(acc, x), term <<< 32);
		end
		return acc;
	endfunction

	function automatic longint unsigned quot_q16(longint unsigned p, longint unsigned d);
		longint unsigned q, r;
		q = p / d;
		r = p % d;
		if (q >= (64'd1 << 32))
			return 64'd1 << 48;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic out_t find_root(in_t req);
		longint signed x, p, d, nx;
		longint unsigned stp;
		int deg;
		int n;
		out_t res;
		x = longint'(req.start_guess);
		deg = int'(degree_reg);
		if (deg < 1)
			deg = 1;
		if (deg > DEG_LIMIT)
			deg = DEG_LIMIT;
		res.found = 1'b0;
		n = 0;
		while (n < ROOT_ITERS) begin
			p = horner(x, deg, 1'b0);
			if (mag(p) <= TOL_Q32) begin
				res.found = 1'b1;
				break;
			end
			d = horner(x, deg, 1'b1);
			if (d == 0)
				break;
			stp = quot_q16(mag(p), mag(d));
			if ((p < 0) != (d < 0))
				nx = x + longint'(stp);
			else
				nx = x - longint'(stp);
			if (nx > 64'sh7FFF_FFFF)
				nx = 64'sh7FFF_FFFF;
			if (nx < -64'sh8000_0000)
				nx = -64'sh8000_0000;
			x = nx;
			n++;
		end
		res.estimate = x[31:0];
		res.iterations = n > 255 ? 8'd255 : 8'(n);
		return res;
	endfunction

	// driver: request side
	always @(posedge clk) begin
		in_took = arst_n && in_ch.valid && in_ch.ready;
		if (in_took) begin
			root_q = {root_q, find_root(in_ch.data)};
			void'(guess_q.pop_front());
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else if (in_ch.valid && !in_took) begin
			// pending request holds until taken
			in_ch.valid <= 1'b1;
		end else if (guess_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
			in_ch.valid <= 1'b1;
			in_ch.data  <= guess_q[0];
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// monitor: result side
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (out_hold > 0) begin
			out_ch.ready <= 1'b0;
			out_hold <= out_hold - 1;
		end else begin
			out_ch.ready <= calm || $urandom_range(99) >= 7;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (root_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $realtime, out_ch.data);
			end else begin
				want = root_q.pop_front();
				if (out_ch.data.estimate !== want.estimate) begin
					errors++;
					$display("%0t: estimate exp %h got %h", $realtime,
						want.estimate, out_ch.data.estimate);
				end
				if (out_ch.data.found !== want.found) begin
					errors++;
					$display("%0t: found exp %b got %b", $realtime,
						want.found, out_ch.data.found);
				end
				if (out_ch.data.iterations !== want.iterations) begin
					errors++;
					$display("%0t: iterations exp %0d got %0d", $realtime,
						want.iterations, out_ch.data.iterations);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("polynomial_newton_root_finder_test: done, errors");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		if (idx == REG_DEGREE)
			degree_reg = val[2:0];
		else
			coef_reg[int'(idx) - 1] = val;
	endtask

	task automatic load_poly(int deg, int c [NUM_COEF]);
		write_reg(REG_DEGREE, 16'(deg));
		for (int k = 0; k < NUM_COEF; k++)
			write_reg(reg_idx_t'(int'(REG_COEF0) + k), 16'(c[k]));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (guess_q.size() == 0 && root_q.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	function automatic in_t near_guess(int span);
		in_t g;
		g.start_guess = ($signed($urandom_range(2 * span)) - span) * 65536
			+ $signed($urandom_range(65535));
		return g;
	endfunction

	initial begin
		int c [NUM_COEF];
		int deg, r, lead;
		in_t g;
		errors   = 0;
		calm     = 1'b0;
		out_hold = 0;
		stall_cnt = 0;
		cfg_we   = 1'b0;
		cfg_idx  = REG_DEGREE;
		cfg_data = '0;
		degree_reg = 3'd1;
		foreach (coef_reg[k])
			coef_reg[k] = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset polynomial is zero: found at once
		guess_q = {guess_q, in_t'(32'h0000_0000)};
		guess_q = {guess_q, in_t'(32'h7FFF_FFFF)};
		guess_q = {guess_q, in_t'(32'h8000_0000)};
		drain();

		// linear, root at 3
		c = '{2, -6, 0, 0, 0, 0, 0};
		load_poly(1, c);
		guess_q = {guess_q, in_t'(32'h0000_0000)};
		guess_q = {guess_q, in_t'(32'h7FFF_FFFF)};
		guess_q = {guess_q, in_t'(32'h8000_0000)};
		guess_q = {guess_q, in_t'(32'h0003_0000)};
		drain();

		// flat nonzero line: zero derivative
		c = '{0, 5, 0, 0, 0, 0, 0};
		load_poly(1, c);
		guess_q = {guess_q, in_t'(32'h0001_8000)};
		drain();

		// x^2 + 1: no real root, the search stops on a zero derivative at x = 0
		c = '{1, 0, 1, 0, 0, 0, 0};
		load_poly(2, c);
		guess_q = {guess_q, in_t'(32'h0001_0000)};
		guess_q = {guess_q, in_t'(32'h0000_0000)};
		drain();

		// extreme coefficients at top degree: saturating sums
		c = '{32767, -32768, 32767, -32768, 32767, -32768, 32767};
		load_poly(6, c);
		guess_q = {guess_q, in_t'(32'h7FFF_FFFF)};
		guess_q = {guess_q, in_t'(32'h8000_0000)};
		drain();

		// degree field 0 acts as 1, 7 acts as 6
		c = '{1, -2, 9, 9, 9, 9, 9};
		load_poly(0, c);
		guess_q = {guess_q, in_t'(32'h0007_0000)};
		drain();
		c = '{1, -1, 0, 0, 0, 0, 0};
		for (int i = 0; i < 5; i++) begin
			for (int k = i + 2; k >= 1; k--)
				c[k] = c[k] - (i - 2) * c[k - 1];
		end
		load_poly(7, c);
		guess_q = {guess_q, in_t'(32'h0003_4000)};
		guess_q = {guess_q, in_t'(32'hFFFC_0000)};
		drain();

		// random polynomials built from integer roots
		for (int ph = 0; ph < 12; ph++) begin
			c = '{0, 0, 0, 0, 0, 0, 0};
			deg = (ph % 4 == 3) ? $urandom_range(6, 4) : $urandom_range(3, 1);
			lead = $urandom_range(1) ? 1 : -2;
			if (ph == 11) lead = 2;
			c[0] = lead;
			for (int i = 0; i < deg; i++) begin
				r = $signed($urandom_range(8)) - 4;
				for (int k = i + 1; k >= 1; k--)
					c[k] = c[k] - r * c[k - 1];
			end
			for (int k = deg + 1; k < NUM_COEF; k++)
				c[k] = $signed($urandom_range(65535)) - 32768;
			if (ph == 5) begin
				// noise: arbitrary coefficients, low degree
				deg = 2;
				c[0] = $signed($urandom_range(65535)) - 32768;
				c[1] = $signed($urandom_range(65535)) - 32768;
				c[2] = -$signed($urandom_range(100));
			end
			load_poly(deg, c);
			calm = (ph == 3);
			if (ph == 7)
				out_hold = 2000;
			for (int i = 0; i < 11; i++) begin
				if ($urandom_range(7) == 0)
					g = in_t'($urandom);
				else
					g = near_guess(6);
				guess_q = {guess_q, g};
			end
			drain();
		end
		calm = 1'b0;

		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("polynomial_newton_root_finder_test: done, clean");
		else
			$display("polynomial_newton_root_finder_test: done, errors");
		$finish;
	end
endmodule
